@@ hdl/lres_pkg.sv @@
// Shared types and constants for the LED ring effect sequencer.
// Used by every module of the block but lres_checker; depends on nothing.
package lres_pkg;

  localparam int unsigned POS_W     = 4;
  localparam int unsigned MAP_W     = 52;
  localparam int unsigned WORD_W    = 16;
  localparam int unsigned RUN_W     = 4;
  localparam int unsigned SPREAD_W  = 3;
  localparam int unsigned FLASH_W   = 4;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 52;

  localparam logic [WORD_W-1:0]   DEFAULT_PATTERN_RST = 16'h0311;
  localparam logic [WORD_W-1:0]   RING_START_RST      = 16'h0700;
  localparam logic [WORD_W-1:0]   ALL_OFF             = 16'hffff;
  localparam logic [RUN_W-1:0]    RUN_LENGTH_RST      = 4'd13;
  localparam logic [MAP_W-1:0]    POSITION_MAP_RST    = 52'h0125763ECAFDB;
  localparam logic [POS_W-1:0]    POS_FIRST           = 4'd1;
  localparam logic [SPREAD_W-1:0] SPREAD_FIRST        = 3'd1;
  localparam logic [SPREAD_W-1:0] SPREAD_LAST         = 3'd7;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_RING  = 2'd1,
    CMD_FLASH = 2'd2,
    CMD_CHECK = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEFAULT_PATTERN = 2'd0,
    CFG_RING_START_MASK = 2'd1,
    CFG_RUN_LENGTH      = 2'd2,
    CFG_POSITION_MAP    = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'b001,
    MODE_RING  = 3'b010,
    MODE_FLASH = 3'b100
  } mode_e;

  typedef enum logic [2:0] {
    PH_LOAD   = 3'b001,
    PH_SPREAD = 3'b010,
    PH_GATHER = 3'b100
  } phase_e;

  typedef struct packed {
    cmd_e             command;
    logic [POS_W-1:0] key;
  } item_t;

  typedef struct packed {
    logic [WORD_W-1:0] led_word;
    logic              effect_done;
  } result_t;

endpackage

@@ hdl/lres_in_reg.sv @@
// Input register of the LED ring effect sequencer: holds one accepted item.
// Depends on lres_pkg.
module lres_in_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  lres_pkg::item_t in_item_i,
  output logic          in_ready_o,
  input  logic          take_i,
  output logic          item_valid_o,
  output lres_pkg::item_t item_o
);
  import lres_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;

  // The slot frees up in the same cycle the step logic consumes its item.
  assign in_ready_o = !valid_q || take_i;
  assign valid_d    = in_ready_o ? in_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

@@ hdl/lres_step.sv @@
// Step logic of the LED ring effect sequencer: configuration registers,
// effect state and the combinational next-state and result logic. Depends on lres_pkg.
module lres_step #(
  parameter int unsigned RING_POSITIONS = 13,
  parameter int unsigned WORD_BITS      = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [lres_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [lres_pkg::CFG_W-1:0]       cfg_data_i,
  input  logic                             step_en_i,
  input  lres_pkg::item_t                  item_i,
  output logic                             has_result_o,
  output lres_pkg::result_t                result_o
);
  import lres_pkg::*;

  localparam int unsigned      MAP_EXT_W  = POS_W * (1 << POS_W);
  localparam logic [POS_W-1:0] POS_LAST   = POS_W'(RING_POSITIONS);
  localparam logic [POS_W:0]   WORD_LIMIT = (POS_W + 1)'(WORD_BITS);

  function automatic logic [POS_W-1:0] clamp_pos(logic [POS_W-1:0] p);
    logic [POS_W-1:0] pc;
    pc = p;
    if (pc < POS_FIRST) pc = POS_FIRST;
    if (pc > POS_LAST)  pc = POS_LAST;
    return pc;
  endfunction

  // Nibbles above the programmed map read as zero.
  function automatic logic [WORD_W-1:0] pos_mask(logic [POS_W-1:0] p,
                                                 logic [MAP_W-1:0] map);
    logic [POS_W-1:0]     pm1;
    logic [POS_W-1:0]     idx;
    logic [MAP_EXT_W-1:0] ext;
    logic [WORD_W-1:0]    mask;
    pm1 = clamp_pos(p) - POS_FIRST;
    ext = {{(MAP_EXT_W - MAP_W){1'b0}}, map};
    idx = ext[{pm1, 2'b00} +: POS_W];
    if ({1'b0, idx} >= WORD_LIMIT) mask = '0;
    else mask = WORD_W'(1) << idx;
    return mask;
  endfunction

  function automatic logic [POS_W-1:0] step_down(logic [POS_W-1:0] p);
    return (p <= POS_FIRST) ? POS_LAST : p - POS_FIRST;
  endfunction

  function automatic logic [POS_W-1:0] step_up(logic [POS_W-1:0] p);
    return (p >= POS_LAST) ? POS_FIRST : p + POS_FIRST;
  endfunction

  // Configuration registers.
  logic [WORD_W-1:0] default_q, start_mask_q;
  logic [RUN_W-1:0]  run_len_q;
  logic [MAP_W-1:0]  map_q;

  // Effect state.
  mode_e               mode_q, mode_d;
  phase_e              phase_q, phase_d;
  logic [POS_W-1:0]    center_q, center_d;
  logic [POS_W-1:0]    left_q, left_d;
  logic [POS_W-1:0]    right_q, right_d;
  logic [SPREAD_W-1:0] spread_q, spread_d;
  logic [WORD_W-1:0]   pattern_q, pattern_d;
  logic [RUN_W-1:0]    ticks_q, ticks_d;
  logic [FLASH_W-1:0]  flash_q, flash_d;
  logic                toggle_q, toggle_d;

  logic [POS_W-1:0]  key_pos, left_sel, right_sel;
  logic              is_start, spreading, effect_tick;
  logic [WORD_W-1:0] mask_c, mask_l, mask_r, word;
  logic [RUN_W-1:0]  start_ticks, ticks_dec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      default_q    <= DEFAULT_PATTERN_RST;
      start_mask_q <= RING_START_RST;
      run_len_q    <= RUN_LENGTH_RST;
      map_q        <= POSITION_MAP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_DEFAULT_PATTERN: default_q    <= cfg_data_i[WORD_W-1:0];
        CFG_RING_START_MASK: start_mask_q <= cfg_data_i[WORD_W-1:0];
        CFG_RUN_LENGTH:      run_len_q    <= cfg_data_i[RUN_W-1:0];
        CFG_POSITION_MAP:    map_q        <= cfg_data_i[MAP_W-1:0];
        default: ;
      endcase
    end
  end

  assign key_pos     = clamp_pos(item_i.key);
  assign is_start    = (item_i.command == CMD_RING) || (item_i.command == CMD_FLASH);
  assign spreading   = (phase_q == PH_SPREAD);
  assign left_sel    = spreading ? step_down(left_q) : left_q;
  assign right_sel   = spreading ? step_up(right_q) : right_q;
  assign mask_c      = pos_mask(is_start ? key_pos : center_q, map_q);
  assign mask_l      = pos_mask(left_sel, map_q);
  assign mask_r      = pos_mask(right_sel, map_q);
  assign start_ticks = (run_len_q == '0) ? RUN_W'(1) : run_len_q;
  assign ticks_dec   = ticks_q - RUN_W'(1);

  always_comb begin
    mode_d       = mode_q;
    phase_d      = phase_q;
    center_d     = center_q;
    left_d       = left_q;
    right_d      = right_q;
    spread_d     = spread_q;
    pattern_d    = pattern_q;
    ticks_d      = ticks_q;
    flash_d      = flash_q;
    toggle_d     = toggle_q;
    word         = '0;
    effect_tick  = 1'b0;
    has_result_o = 1'b1;
    result_o.effect_done = 1'b0;

    unique case (item_i.command)
      CMD_RING: begin
        center_d = key_pos;
        phase_d  = PH_LOAD;
        mode_d   = MODE_RING;
        ticks_d  = start_ticks;
        word     = start_mask_q | mask_c;
      end
      CMD_FLASH: begin
        center_d = key_pos;
        flash_d  = '0;
        mode_d   = MODE_FLASH;
        ticks_d  = start_ticks;
        word     = default_q;
      end
      CMD_CHECK: begin
        word     = toggle_q ? default_q : ALL_OFF;
        toggle_d = !toggle_q;
      end
      default: begin
        unique case (mode_q)
          MODE_RING: begin
            effect_tick = 1'b1;
            unique case (phase_q)
              PH_SPREAD: begin
                left_d    = left_sel;
                right_d   = right_sel;
                pattern_d = pattern_q | mask_l | mask_r;
                word      = pattern_d;
                spread_d  = spread_q + SPREAD_FIRST;
                if (spread_d >= SPREAD_LAST) phase_d = PH_GATHER;
              end
              PH_GATHER: begin
                pattern_d = pattern_q & ~(mask_l | mask_r);
                word      = pattern_d;
                right_d   = step_down(right_q);
                left_d    = step_up(left_q);
                spread_d  = spread_q - SPREAD_FIRST;
                if (spread_d <= SPREAD_FIRST) phase_d = PH_LOAD;
              end
              default: begin
                // Reload the base pattern; the key bit shows only in the output.
                pattern_d = default_q;
                word      = default_q | mask_c;
                left_d    = center_q;
                right_d   = center_q;
                spread_d  = SPREAD_FIRST;
                phase_d   = PH_SPREAD;
              end
            endcase
          end
          MODE_FLASH: begin
            effect_tick = 1'b1;
            flash_d     = flash_q + FLASH_W'(1);
            word        = flash_d[0] ? (default_q & ~mask_c) : (default_q | mask_c);
          end
          default: has_result_o = 1'b0;
        endcase
        if (effect_tick) begin
          ticks_d = ticks_dec;
          if (ticks_dec == '0) begin
            result_o.effect_done = 1'b1;
            mode_d               = MODE_IDLE;
          end
        end
      end
    endcase
    result_o.led_word = word;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_IDLE;
      phase_q   <= PH_LOAD;
      center_q  <= POS_FIRST;
      left_q    <= POS_FIRST;
      right_q   <= POS_FIRST;
      spread_q  <= '0;
      pattern_q <= DEFAULT_PATTERN_RST;
      ticks_q   <= '0;
      flash_q   <= '0;
      toggle_q  <= 1'b0;
    end else if (step_en_i) begin
      mode_q    <= mode_d;
      phase_q   <= phase_d;
      center_q  <= center_d;
      left_q    <= left_d;
      right_q   <= right_d;
      spread_q  <= spread_d;
      pattern_q <= pattern_d;
      ticks_q   <= ticks_d;
      flash_q   <= flash_d;
      toggle_q  <= toggle_d;
    end
  end

endmodule

@@ hdl/lres_out_reg.sv @@
// Result register of the LED ring effect sequencer: holds one result item
// until the downstream side takes it. Depends on lres_pkg.
module lres_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  lres_pkg::result_t result_i,
  output logic              free_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output lres_pkg::result_t result_o
);
  import lres_pkg::*;

  logic    valid_q, valid_d;
  result_t result_q;

  assign free_o  = !valid_q || out_ready_i;
  assign valid_d = load_i ? 1'b1 : (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

@@ hdl/led_ring_effect_sequencer_top.sv @@
// Top level of the LED ring effect sequencer.
// Depends on lres_pkg, lres_in_reg, lres_step and lres_out_reg.
//
// This block turns commands (tick, start ring, start flash, device check)
// into active-low 16-bit LED words for a ring of panel LEDs. It accepts one
// item per clock cycle when the output side keeps up. A result is offered
// from the result register: the item is held in the input register while
// the step logic works on it, and the result register takes the result once
// it has room. A tick while no effect runs produces no result and passes
// through without needing room at the output. The input side stalls only
// when an item with a result waits for a full result register that is not
// being drained. Configuration registers are written through the cfg port,
// one per cycle, and should change only while no item is in flight; writes
// take effect on the next item. The last result of an effect run carries
// tlast.
module led_ring_effect_sequencer_top #(
  parameter int unsigned RING_POSITIONS = 13,
  parameter int unsigned WORD_BITS      = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write port.
  input  logic                           cfg_we_i,
  input  logic [lres_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [lres_pkg::CFG_W-1:0]     cfg_data_i,
  // Input stream.
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,  // [3:0] key, [7:4] zero
  input  logic [1:0]                     s_axis_tuser,  // [1:0] command
  // Output stream.
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [15:0]                    m_axis_tdata,  // [15:0] led_word
  output logic                           m_axis_tlast   // effect_done
);
  import lres_pkg::*;

  item_t   in_item, item;
  result_t step_result, out_result;
  logic    item_valid, has_result, out_free, step_en, out_load;

  assign in_item.command = cmd_e'(s_axis_tuser);
  assign in_item.key     = s_axis_tdata[POS_W-1:0];

  // The held item advances when it yields no result or the result register
  // has room (empty, or emptying in this cycle).
  assign step_en  = item_valid && (!has_result || out_free);
  assign out_load = step_en && has_result;

  lres_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_item_i    (in_item),
    .in_ready_o   (s_axis_tready),
    .take_i       (step_en),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  lres_step #(
    .RING_POSITIONS (RING_POSITIONS),
    .WORD_BITS      (WORD_BITS)
  ) u_step (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .step_en_i    (step_en),
    .item_i       (item),
    .has_result_o (has_result),
    .result_o     (step_result)
  );

  lres_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (out_load),
    .result_i    (step_result),
    .free_o      (out_free),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .result_o    (out_result)
  );

  assign m_axis_tdata = out_result.led_word;
  assign m_axis_tlast = out_result.effect_done;

endmodule

@@ hdl/lres_checker.sv @@
// Port-level checks for the LED ring effect sequencer, bound to the top level.
// Depends on led_ring_effect_sequencer_top.
module lres_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // A stalled result stays offered.
  a_out_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result item withdrawn while stalled");

  // A stalled result keeps its payload.
  a_out_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result item changed while stalled");

  // The input side only stalls behind a full, undrained result register.
  a_in_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output back-pressure");

  // Reset empties both registers.
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid && s_axis_tready)
    else $error("block not empty after reset");

endmodule

bind led_ring_effect_sequencer_top lres_checker u_lres_checker (.*);

@@ tb/sv/led_ring_effect_sequencer_top_test.sv @@
// Self-checking testbench for the LED ring effect sequencer top level.
// Depends on lres_pkg and led_ring_effect_sequencer_top; it instantiates no other module.
// A predictor inside the bench computes each expected LED word and done flag.
`timescale 1ns / 100ps

module led_ring_effect_sequencer_top_test;
  import lres_pkg::*;

  // The block's own ring size, mirrored here so the predictor wraps positions alike.
  localparam int unsigned RING_POSITIONS = 13;
  // Cycles without any item moved on either stream before the run is declared hung.
  // The longest correct quiet stretch is the deliberate output hold-off below.
  localparam int unsigned HANG_LIMIT     = 3000;
  localparam int unsigned HOLD_CYCLES    = 150;
  // Settling time for the pipeline registers, with some margin.
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned IDLE_PERCENT   = 17;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i     = '0;
  logic [CFG_W-1:0]     cfg_data_i    = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata  = '0;  // [3:0] key, [7:4] zero
  logic [1:0]           s_axis_tuser  = '0;  // [1:0] command
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [15:0]          m_axis_tdata;        // [15:0] led_word
  logic                 m_axis_tlast;        // effect_done

  led_ring_effect_sequencer_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // Configuration as the predictor believes it to be, starting at the reset values.
  logic [WORD_W-1:0] cfg_default    = DEFAULT_PATTERN_RST;
  logic [WORD_W-1:0] cfg_ring_start = RING_START_RST;
  logic [RUN_W-1:0]  cfg_run        = RUN_LENGTH_RST;
  logic [MAP_W-1:0]  cfg_map        = POSITION_MAP_RST;

  // Effect state of the predictor, again at reset values.
  mode_e               st_mode    = MODE_IDLE;
  phase_e              st_phase   = PH_LOAD;
  logic [POS_W-1:0]    st_center  = POS_FIRST;
  logic [POS_W-1:0]    st_left    = POS_FIRST;
  logic [POS_W-1:0]    st_right   = POS_FIRST;
  logic [SPREAD_W-1:0] st_spread  = '0;
  logic [WORD_W-1:0]   st_pattern = DEFAULT_PATTERN_RST;
  logic [RUN_W-1:0]    st_ticks   = '0;
  logic [FLASH_W-1:0]  st_flash   = '0;
  logic                st_toggle  = 1'b0;

  // LED words still owed by the block, oldest first.
  result_t pending_words[$];

  int error_count     = 0;
  int items_sent      = 0;
  int words_predicted = 0;
  int words_checked   = 0;
  int settings_done   = 0;

  // Knobs shared between the test tasks and the stream processes.
  bit tx_steady     = 1'b0;  // sender never idles while set
  bit rx_steady     = 1'b0;  // receiver never idles while set, outside a hold-off
  int hold_requests = 0;     // bumped by a test to ask for one long output hold-off
  int hold_served   = 0;     // owned by the receiver process
  int hold_left     = 0;

  // Word bit that a ring position lights; positions here are always 1..13.
  function automatic logic [WORD_W-1:0] led_bit(logic [POS_W-1:0] pos);
    logic [3:0] idx;
    idx = cfg_map[4 * (int'(pos) - 1) +: 4];
    return 16'h0001 << idx;
  endfunction

  // A run length of zero behaves as a single tick.
  function automatic logic [RUN_W-1:0] run_ticks();
    return (cfg_run == '0) ? 4'd1 : cfg_run;
  endfunction

  // Advances the predicted state by one item. Returns 1 with the expected word
  // when the item produces one, 0 for a tick while no effect runs.
  function automatic bit predict_led_word(input cmd_e cmd, input logic [POS_W-1:0] key,
                                          output result_t res);
    logic [WORD_W-1:0] word;
    logic              done;
    logic [POS_W-1:0]  pos;
    word = '0;
    done = 1'b0;
    res  = '0;
    // Out-of-range keys pin to the nearest end of the ring.
    pos  = (key == 4'd0) ? POS_FIRST :
           ((key > 4'(RING_POSITIONS)) ? 4'(RING_POSITIONS) : key);
    case (cmd)
      CMD_RING: begin
        st_center = pos;
        st_phase  = PH_LOAD;
        st_mode   = MODE_RING;
        st_ticks  = run_ticks();
        word      = cfg_ring_start | led_bit(pos);
      end
      CMD_FLASH: begin
        st_center = pos;
        st_flash  = '0;
        st_mode   = MODE_FLASH;
        st_ticks  = run_ticks();
        word      = cfg_default;
      end
      CMD_CHECK: begin
        // Device check leaves any running effect alone.
        word      = st_toggle ? cfg_default : ALL_OFF;
        st_toggle = ~st_toggle;
      end
      default: begin
        if (st_mode == MODE_RING) begin
          case (st_phase)
            PH_SPREAD: begin
              st_left    = (st_left <= 4'd1) ? 4'(RING_POSITIONS) : st_left - 4'd1;
              st_right   = (st_right >= 4'(RING_POSITIONS)) ? 4'd1 : st_right + 4'd1;
              st_pattern = st_pattern | led_bit(st_left) | led_bit(st_right);
              word       = st_pattern;
              st_spread  = st_spread + 3'd1;
              if (st_spread >= SPREAD_LAST) st_phase = PH_GATHER;
            end
            PH_GATHER: begin
              st_pattern = st_pattern & ~(led_bit(st_left) | led_bit(st_right));
              word       = st_pattern;
              st_right   = (st_right <= 4'd1) ? 4'(RING_POSITIONS) : st_right - 4'd1;
              st_left    = (st_left >= 4'(RING_POSITIONS)) ? 4'd1 : st_left + 4'd1;
              st_spread  = st_spread - 3'd1;
              if (st_spread <= SPREAD_FIRST) st_phase = PH_LOAD;
            end
            default: begin
              // The stored pattern keeps the key bit as the default has it.
              st_pattern = cfg_default;
              word       = st_pattern | led_bit(st_center);
              st_left    = st_center;
              st_right   = st_center;
              st_spread  = SPREAD_FIRST;
              st_phase   = PH_SPREAD;
            end
          endcase
        end else if (st_mode == MODE_FLASH) begin
          st_flash = st_flash + 4'd1;
          word = st_flash[0] ? (cfg_default & ~led_bit(st_center))
                             : (cfg_default | led_bit(st_center));
        end else begin
          return 1'b0;
        end
        st_ticks = st_ticks - 4'd1;
        if (st_ticks == '0) begin
          done    = 1'b1;
          st_mode = MODE_IDLE;
        end
      end
    endcase
    res.led_word    = word;
    res.effect_done = done;
    return 1'b1;
  endfunction

  // Offers one item, possibly after random idle cycles, and waits until it is taken.
  // Each cycle idles with the same chance, so the sender idles in about that share
  // of its cycles. The valid is left high on return, so back-to-back items never
  // drop it.
  task automatic send_item(cmd_e cmd, logic [POS_W-1:0] key);
    result_t res;
    while (!tx_steady && $urandom_range(99) < IDLE_PERCENT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {4'b0000, key};
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    if (predict_led_word(cmd, key, res)) begin
      pending_words.push_back(res);
      words_predicted++;
    end
  endtask

  // Stops offering items and waits until every expected word has come back,
  // then lets a silent tick still in the pipeline drain out.
  task automatic finish_phase();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes all four registers, one per cycle, with the block idle.
  task automatic set_config(logic [WORD_W-1:0] dflt, logic [WORD_W-1:0] start_mask,
                            logic [RUN_W-1:0] run_len, logic [MAP_W-1:0] pos_map);
    logic [CFG_W-1:0] vals[4];
    vals[CFG_DEFAULT_PATTERN] = CFG_W'(dflt);
    vals[CFG_RING_START_MASK] = CFG_W'(start_mask);
    vals[CFG_RUN_LENGTH]      = CFG_W'(run_len);
    vals[CFG_POSITION_MAP]    = pos_map;
    for (int i = 0; i < 4; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= cfg_idx_e'(i);
      cfg_data_i <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i       <= 1'b0;
    cfg_default    = dflt;
    cfg_ring_start = start_mask;
    cfg_run        = run_len;
    cfg_map        = pos_map;
    settings_done++;
  endtask

  // Mostly well-formed effect runs (a start then ticks that may stop short of,
  // reach or pass the run's end), with device checks and random noise mixed in.
  // Stops once the wanted number of LED words has been predicted.
  task automatic drive_effect_runs(int want);
    int               goal;
    int               pick;
    int               ticks;
    logic [POS_W-1:0] key;
    goal = words_predicted + want;
    while (words_predicted < goal) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        key = ($urandom_range(99) < 15) ? 4'($urandom_range(15)) : 4'($urandom_range(1, 13));
        send_item(($urandom_range(1) != 0) ? CMD_RING : CMD_FLASH, key);
        ticks = $urandom_range(1, int'(run_ticks()) + 2);
        repeat (ticks) begin
          if ($urandom_range(99) < 6) send_item(CMD_CHECK, 4'($urandom_range(15)));
          send_item(CMD_TICK, 4'($urandom_range(15)));
        end
      end else if (pick < 85) begin
        send_item(CMD_CHECK, 4'($urandom_range(15)));
      end else begin
        send_item(cmd_e'($urandom_range(3)), 4'($urandom_range(15)));
      end
    end
  endtask

  // Hand-picked sequence at reset configuration: idle tick, both device-check
  // states, clamped keys at both ends, restart of a run in progress, a check in
  // the middle of an effect, and one full ring cycle that wraps past position 13
  // and ends exactly on the done flag.
  task automatic test_directed();
    send_item(CMD_TICK, 4'hA);
    send_item(CMD_CHECK, 4'h0);
    send_item(CMD_CHECK, 4'hF);
    send_item(CMD_RING, 4'h0);
    send_item(CMD_TICK, 4'h5);
    send_item(CMD_FLASH, 4'hF);
    send_item(CMD_TICK, 4'h0);
    send_item(CMD_TICK, 4'hF);
    send_item(CMD_CHECK, 4'h3);
    send_item(CMD_TICK, 4'h9);
    send_item(CMD_RING, 4'd13);
    repeat (13) send_item(CMD_TICK, 4'h0);
    send_item(CMD_TICK, 4'h6);
    finish_phase();
  endtask

  // Every register at its extremes, including a run length of zero and maps
  // that send all positions to bit 0 or all to bit 15.
  task automatic test_config_extremes();
    set_config(16'h0000, 16'hFFFF, 4'd0, '0);
    drive_effect_runs(25);
    finish_phase();
    set_config(16'hFFFF, 16'h0000, 4'd1, {MAP_W{1'b1}});
    drive_effect_runs(25);
    finish_phase();
    set_config(16'($urandom), 16'($urandom), 4'd15, MAP_W'({$urandom, $urandom}));
    drive_effect_runs(40);
    finish_phase();
    set_config(DEFAULT_PATTERN_RST, RING_START_RST, RUN_LENGTH_RST, POSITION_MAP_RST);
    drive_effect_runs(25);
    finish_phase();
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering
  // items back to back, so the block fills and stalls its input. The sender then
  // pauses until every expected word has arrived.
  task automatic test_output_stall();
    hold_requests++;
    tx_steady = 1'b1;
    repeat (3) begin
      send_item(CMD_RING, 4'($urandom_range(1, 13)));
      repeat (12) send_item(CMD_TICK, 4'($urandom_range(15)));
    end
    tx_steady = 1'b0;
    finish_phase();
  endtask

  // Random configurations, one phase each; the third phase runs with no idling
  // on either side.
  task automatic test_random();
    for (int ph = 0; ph < 4; ph++) begin
      set_config(16'($urandom), 16'($urandom), 4'($urandom_range(15)),
                 MAP_W'({$urandom, $urandom}));
      tx_steady = (ph == 2);
      rx_steady = (ph == 2);
      drive_effect_runs(160);
      finish_phase();
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  // Receiver: random back-pressure, plus a long hold-off when a test asks for one.
  always @(posedge clk_i) begin
    if (hold_served != hold_requests) begin
      hold_served++;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= rx_steady || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  // Compares every word the block hands over with the oldest prediction.
  always @(posedge clk_i) begin : check_words
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_words.size() == 0) begin
        error_count++;
        $display("%0t: unexpected word %h done %b with nothing pending",
                 $time, m_axis_tdata, m_axis_tlast);
      end else begin
        want = pending_words.pop_front();
        words_checked++;
        if (m_axis_tdata !== want.led_word) begin
          error_count++;
          $display("%0t: led_word expected %h actual %h", $time, want.led_word, m_axis_tdata);
        end
        if (m_axis_tlast !== want.effect_done) begin
          error_count++;
          $display("%0t: effect_done expected %b actual %b",
                   $time, want.effect_done, m_axis_tlast);
        end
      end
    end
  end

  // Watchdog: ends the run if nothing moves on either stream for too long.
  always @(posedge clk_i) begin : watchdog
    int quiet;
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= HANG_LIMIT) begin
        $display("%0t: no item moved for %0d cycles, %0d words still pending",
                 $time, quiet, pending_words.size());
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_config_extremes();
    test_output_stall();
    test_random();
    finish_phase();
    $display("Sent %0d items and checked %0d LED words over %0d register settings.",
             items_sent, words_checked, settings_done);
    $display("Ring, flash and device-check runs ran with random gaps and a long output stall.");
    if (error_count == 0 && pending_words.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/lres_pkg.sv
hdl/lres_in_reg.sv
hdl/lres_step.sv
hdl/lres_out_reg.sv
hdl/led_ring_effect_sequencer_top.sv
hdl/lres_checker.sv
tb/sv/led_ring_effect_sequencer_top_test.sv
